// ===== rtl/tcch_pkg.sv =====
// ---------------------------------------------------------------------------
// tcch_pkg
// Shared types, constants and the CORDIC arctangent table for the
// tilt compensated compass heading pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package tcch_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int MAX_STEPS        = 24;

  localparam int CFG_W  = 16;
  localparam int ADDR_W = 3;

  localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam int ANG_W = 32;

  typedef enum logic [ADDR_W-1:0] {
    REG_X_OFFSET = 3'd0,
    REG_Y_OFFSET = 3'd1,
    REG_Z_OFFSET = 3'd2,
    REG_Y_GAIN   = 3'd3,
    REG_Z_GAIN   = 3'd4
  } cfg_reg_t;

  // atan(2^-i) in 1/6553600 degree
  function automatic logic signed [ANG_W-1:0] atan_val(input int idx);
    logic signed [ANG_W-1:0] v;
    begin
      unique case (idx)
        0: v = 32'sd294912000;
        1: v = 32'sd174096719;
        2: v = 32'sd91987925;
        3: v = 32'sd46694509;
        4: v = 32'sd23437865;
        5: v = 32'sd11730358;
        6: v = 32'sd5866610;
        7: v = 32'sd2933484;
        8: v = 32'sd1466764;
        9: v = 32'sd733385;
        10: v = 32'sd366693;
        11: v = 32'sd183346;
        12: v = 32'sd91673;
        13: v = 32'sd45837;
        14: v = 32'sd22918;
        15: v = 32'sd11459;
        16: v = 32'sd5730;
        17: v = 32'sd2865;
        18: v = 32'sd1432;
        19: v = 32'sd716;
        20: v = 32'sd358;
        21: v = 32'sd179;
        22: v = 32'sd90;
        23: v = 32'sd45;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tilt_compensated_compass_heading.sv =====
// An input word reaches the result word through tcch_front, the unrolled
// rotation CORDIC, the p, q and s registers and the unrolled vectoring CORDIC.
// Throughput: one word per cycle; the whole pipeline holds when a result
// waits on out_ready.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// offsets with zero and both gains with 16384.
// ---------------------------------------------------------------------------
// tilt_compensated_compass_heading
// Magnetometer calibration, tilt compensation and heading pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module tilt_compensated_compass_heading import tcch_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_raw_x,
  input  wire logic [15:0]        in_raw_y,
  input  wire logic [15:0]        in_raw_z,
  input  wire logic signed [15:0] in_tilt_x,
  input  wire logic signed [15:0] in_tilt_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [17:0]      out_cal_x,
  output logic signed [19:0]      out_cal_y,
  output logic signed [19:0]      out_cal_z,
  output logic [15:0]             out_heading,
  input  wire logic               cfg_we,
  input  wire logic [ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  localparam int RSB_W = 18 + 34 + 34;
  localparam int VSB_W = 18 + 20 + 20;

  logic adv;

  logic signed [CFG_W-1:0] x_off_r;
  logic signed [CFG_W-1:0] y_off_r;
  logic signed [CFG_W-1:0] z_off_r;
  logic [CFG_W-1:0]        y_gain_r;
  logic [CFG_W-1:0]        z_gain_r;

  logic                    f_valid;
  logic signed [17:0]      f_mx;
  logic signed [33:0]      f_py;
  logic signed [33:0]      f_pz;
  logic signed [ANG_W-1:0] f_za;
  logic signed [ANG_W-1:0] f_zb;
  logic                    f_fa;
  logic                    f_fb;

  logic                    r_valid;
  logic signed [31:0]      r_cx;
  logic signed [31:0]      r_sx;
  logic signed [31:0]      r_cy;
  logic signed [31:0]      r_sy;
  logic [RSB_W-1:0]        r_sb;

  logic signed [17:0]      r_mx;
  logic signed [33:0]      r_py;
  logic signed [33:0]      r_pz;
  logic signed [33:0]      py_adj;
  logic signed [33:0]      pz_adj;

  logic                    p_valid_r;
  logic signed [17:0]      p_mx_r;
  logic signed [19:0]      p_my_r;
  logic signed [19:0]      p_mz_r;
  logic signed [31:0]      p_cx_r;
  logic signed [31:0]      p_cy_r;
  logic signed [31:0]      p_sy_r;
  logic signed [63:0]      p_p1_r;
  logic signed [63:0]      p_p2_r;

  logic signed [31:0]      p1;
  logic signed [31:0]      p2;
  logic signed [63:0]      p1_sh;
  logic signed [63:0]      p2_sh;

  logic                    q_valid_r;
  logic signed [17:0]      q_mx_r;
  logic signed [19:0]      q_my_r;
  logic signed [19:0]      q_mz_r;
  logic signed [49:0]      q_t1_r;
  logic signed [51:0]      q_t2_r;
  logic signed [51:0]      q_t3_r;
  logic signed [51:0]      q_t4_r;
  logic signed [51:0]      q_t5_r;

  logic                    s_valid_r;
  logic [VSB_W-1:0]        s_sb_r;
  logic signed [53:0]      s_xh_r;
  logic signed [53:0]      s_yh_r;

  logic [VSB_W-1:0]        v_sb;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r  <= '0;
      y_off_r  <= '0;
      z_off_r  <= '0;
      y_gain_r <= 16'd16384;
      z_gain_r <= 16'd16384;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_X_OFFSET: x_off_r  <= cfg_wdata;
        REG_Y_OFFSET: y_off_r  <= cfg_wdata;
        REG_Z_OFFSET: z_off_r  <= cfg_wdata;
        REG_Y_GAIN:   y_gain_r <= cfg_wdata;
        REG_Z_GAIN:   z_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcch_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .raw_x     (in_raw_x),
    .raw_y     (in_raw_y),
    .raw_z     (in_raw_z),
    .tilt_x    (in_tilt_x),
    .tilt_y    (in_tilt_y),
    .x_offset  (x_off_r),
    .y_offset  (y_off_r),
    .z_offset  (z_off_r),
    .y_gain    (y_gain_r),
    .z_gain    (z_gain_r),
    .out_valid (f_valid),
    .mx        (f_mx),
    .py        (f_py),
    .pz        (f_pz),
    .za        (f_za),
    .zb        (f_zb),
    .flip_a    (f_fa),
    .flip_b    (f_fb)
  );

  tcch_rot #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SB_W         (RSB_W)
  ) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f_valid),
    .in_za     (f_za),
    .in_zb     (f_zb),
    .in_flip_a (f_fa),
    .in_flip_b (f_fb),
    .in_sb     ({f_mx, f_py, f_pz}),
    .out_valid (r_valid),
    .out_cos_a (r_cx),
    .out_sin_a (r_sx),
    .out_cos_b (r_cy),
    .out_sin_b (r_sy),
    .out_sb    (r_sb)
  );

  assign r_mx = r_sb[RSB_W-1 -: 18];
  assign r_py = r_sb[67:34];
  assign r_pz = r_sb[33:0];

  // truncate toward zero on the q14 gain
  assign py_adj = r_py[33] ? r_py + 34'sd16383 : r_py;
  assign pz_adj = r_pz[33] ? r_pz + 34'sd16383 : r_pz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      q_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= r_valid;
      q_valid_r <= p_valid_r;
      s_valid_r <= q_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_mx_r <= r_mx;
      p_my_r <= py_adj[33:14];
      p_mz_r <= pz_adj[33:14];
      p_cx_r <= r_cx;
      p_cy_r <= r_cy;
      p_sy_r <= r_sy;
      p_p1_r <= 64'(r_sy) * 64'(r_sx);
      p_p2_r <= 64'(r_cy) * 64'(r_sx);
    end
  end

  assign p1_sh = p_p1_r >>> 30;
  assign p2_sh = p_p2_r >>> 30;
  assign p1    = p1_sh[31:0];
  assign p2    = p2_sh[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      q_mx_r <= p_mx_r;
      q_my_r <= p_my_r;
      q_mz_r <= p_mz_r;
      q_t1_r <= 50'(p_mx_r) * 50'(p_cx_r);
      q_t2_r <= 52'(p_my_r) * 52'(p1);
      q_t3_r <= 52'(p_mz_r) * 52'(p2);
      q_t4_r <= 52'(p_my_r) * 52'(p_cy_r);
      q_t5_r <= 52'(p_mz_r) * 52'(p_sy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_sb_r <= {q_mx_r, q_my_r, q_mz_r};
      s_xh_r <= 54'(q_t1_r) + 54'(q_t2_r) - 54'(q_t3_r);
      s_yh_r <= 54'(q_t4_r) + 54'(q_t5_r);
    end
  end

  tcch_vec #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SB_W         (VSB_W)
  ) u_vec (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (s_valid_r),
    .in_xh       (s_xh_r),
    .in_yh       (s_yh_r),
    .in_sb       (s_sb_r),
    .out_valid   (out_valid),
    .out_heading (out_heading),
    .out_sb      (v_sb)
  );

  assign out_cal_x = v_sb[VSB_W-1 -: 18];
  assign out_cal_y = v_sb[39:20];
  assign out_cal_z = v_sb[19:0];

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading < 16'd36000)
    else $error("heading out of range");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(p_valid_r) && $stable(s_valid_r) && $stable(s_xh_r))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== rtl/tcch_front.sv =====
// ---------------------------------------------------------------------------
// tcch_front
// First stage: axis offset and gain products, tilt angle folding.
// ---------------------------------------------------------------------------
`default_nettype none

module tcch_front import tcch_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [15:0]              raw_x,
  input  wire logic [15:0]              raw_y,
  input  wire logic [15:0]              raw_z,
  input  wire logic signed [15:0]       tilt_x,
  input  wire logic signed [15:0]       tilt_y,
  input  wire logic signed [CFG_W-1:0]  x_offset,
  input  wire logic signed [CFG_W-1:0]  y_offset,
  input  wire logic signed [CFG_W-1:0]  z_offset,
  input  wire logic [CFG_W-1:0]         y_gain,
  input  wire logic [CFG_W-1:0]         z_gain,
  output logic                          out_valid,
  output logic signed [17:0]            mx,
  output logic signed [33:0]            py,
  output logic signed [33:0]            pz,
  output logic signed [ANG_W-1:0]       za,
  output logic signed [ANG_W-1:0]       zb,
  output logic                          flip_a,
  output logic                          flip_b
);

  function automatic logic signed [16:0] sext_s(input logic [15:0] v);
    logic signed [16:0] r;
    begin
      r = {{(17-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v[SAMPLE_BITS-1:0]};
      return r;
    end
  endfunction

  // negate, wrap to +-180, fold to +-90
  function automatic logic [ANG_W:0] fold(input logic signed [15:0] t);
    logic signed [16:0] a;
    logic signed [16:0] w;
    logic signed [16:0] f;
    logic               fl;
    logic signed [ANG_W-1:0] z;
    begin
      a = -{t[15], t};
      if (a >= 17'sd18000) w = a - 17'sd36000;
      else if (a < -17'sd18000) w = a + 17'sd36000;
      else w = a;
      fl = 1'b0;
      f  = w;
      if (w > 17'sd9000) begin
        f  = w - 17'sd18000;
        fl = 1'b1;
      end else if (w < -17'sd9000) begin
        f  = w + 17'sd18000;
        fl = 1'b1;
      end
      z = ANG_W'(f) <<< 16;
      return {fl, z};
    end
  endfunction

  logic signed [16:0] dy;
  logic signed [16:0] dz;
  logic [ANG_W:0]     fa;
  logic [ANG_W:0]     fb;

  logic                    valid_r;
  logic signed [17:0]      mx_r;
  logic signed [33:0]      py_r;
  logic signed [33:0]      pz_r;
  logic signed [ANG_W-1:0] za_r;
  logic signed [ANG_W-1:0] zb_r;
  logic                    flip_a_r;
  logic                    flip_b_r;

  assign dy = sext_s(raw_y) - {y_offset[15], y_offset};
  assign dz = sext_s(raw_z) - {z_offset[15], z_offset};
  assign fa = fold(tilt_x);
  assign fb = fold(tilt_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r     <= -18'(sext_s(raw_x)) - 18'(x_offset);
      py_r     <= 34'(dy) * $signed({18'd0, y_gain});
      pz_r     <= 34'(dz) * $signed({18'd0, z_gain});
      za_r     <= fa[ANG_W-1:0];
      zb_r     <= fb[ANG_W-1:0];
      flip_a_r <= fa[ANG_W];
      flip_b_r <= fb[ANG_W];
    end
  end

  assign out_valid = valid_r;
  assign mx        = mx_r;
  assign py        = py_r;
  assign pz        = pz_r;
  assign za        = za_r;
  assign zb        = zb_r;
  assign flip_a    = flip_a_r;
  assign flip_b    = flip_b_r;

endmodule

`default_nettype wire

// ===== rtl/tcch_rot.sv =====
// ---------------------------------------------------------------------------
// tcch_rot
// Unrolled rotation CORDIC, two lanes, giving Q30 sine and cosine.
// ---------------------------------------------------------------------------
`default_nettype none

module tcch_rot import tcch_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int SB_W         = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [ANG_W-1:0] in_za,
  input  wire logic signed [ANG_W-1:0] in_zb,
  input  wire logic                    in_flip_a,
  input  wire logic                    in_flip_b,
  input  wire logic [SB_W-1:0]         in_sb,
  output logic                         out_valid,
  output logic signed [31:0]           out_cos_a,
  output logic signed [31:0]           out_sin_a,
  output logic signed [31:0]           out_cos_b,
  output logic signed [31:0]           out_sin_b,
  output logic [SB_W-1:0]              out_sb
);

  localparam int STEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int RW = 33;

  logic signed [RW-1:0]    x_r  [2][STEPS];
  logic signed [RW-1:0]    y_r  [2][STEPS];
  logic signed [ANG_W-1:0] z_r  [2][STEPS];
  logic                    fl_r [2][STEPS];
  logic [SB_W-1:0]         sb_r [STEPS];
  logic                    v_r  [STEPS];

  logic signed [ANG_W-1:0] z_in  [2];
  logic                    fl_in [2];

  logic                    valid_o_r;
  logic signed [31:0]      cos_o_r [2];
  logic signed [31:0]      sin_o_r [2];
  logic [SB_W-1:0]         sb_o_r;

  assign z_in[0]  = in_za;
  assign z_in[1]  = in_zb;
  assign fl_in[0] = in_flip_a;
  assign fl_in[1] = in_flip_b;

  for (genvar i = 0; i < STEPS; i++) begin : g_stg
    logic [SB_W-1:0] sb_s;
    logic            v_s;
    if (i == 0) begin : g_first
      assign sb_s = in_sb;
      assign v_s  = in_valid;
    end else begin : g_next
      assign sb_s = sb_r[i-1];
      assign v_s  = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[i] <= sb_s;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [RW-1:0]    xs;
      logic signed [RW-1:0]    ys;
      logic signed [ANG_W-1:0] zs;
      logic                    fs;
      if (i == 0) begin : g_first
        assign xs = INV_GAIN_Q30;
        assign ys = '0;
        assign zs = z_in[l];
        assign fs = fl_in[l];
      end else begin : g_next
        assign xs = x_r[l][i-1];
        assign ys = y_r[l][i-1];
        assign zs = z_r[l][i-1];
        assign fs = fl_r[l][i-1];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (!zs[ANG_W-1]) begin
            x_r[l][i] <= xs - (ys >>> i);
            y_r[l][i] <= ys + (xs >>> i);
            z_r[l][i] <= zs - atan_val(i);
          end else begin
            x_r[l][i] <= xs + (ys >>> i);
            y_r[l][i] <= ys - (xs >>> i);
            z_r[l][i] <= zs + atan_val(i);
          end
          fl_r[l][i] <= fs;
        end
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_out
    always_ff @(posedge clk) begin
      if (en) begin
        if (fl_r[l][STEPS-1]) begin
          cos_o_r[l] <= 32'(-x_r[l][STEPS-1]);
          sin_o_r[l] <= 32'(-y_r[l][STEPS-1]);
        end else begin
          cos_o_r[l] <= 32'(x_r[l][STEPS-1]);
          sin_o_r[l] <= 32'(y_r[l][STEPS-1]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o_r <= 1'b0;
    end else if (en) begin
      valid_o_r <= v_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_o_r <= sb_r[STEPS-1];
    end
  end

  assign out_valid = valid_o_r;
  assign out_cos_a = cos_o_r[0];
  assign out_sin_a = sin_o_r[0];
  assign out_cos_b = cos_o_r[1];
  assign out_sin_b = sin_o_r[1];
  assign out_sb    = sb_o_r;

endmodule

`default_nettype wire

// ===== rtl/tcch_vec.sv =====
// ---------------------------------------------------------------------------
// tcch_vec
// Unrolled vectoring CORDIC producing the heading in centidegrees.
// ---------------------------------------------------------------------------
`default_nettype none

module tcch_vec import tcch_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int SB_W         = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic signed [53:0]  in_xh,
  input  wire logic signed [53:0]  in_yh,
  input  wire logic [SB_W-1:0]     in_sb,
  output logic                     out_valid,
  output logic [15:0]              out_heading,
  output logic [SB_W-1:0]          out_sb
);

  localparam int STEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int VW = 57;

  logic                    p_valid_r;
  logic signed [VW-1:0]    p_x_r;
  logic signed [VW-1:0]    p_y_r;
  logic                    p_neg_r;
  logic                    p_zero_r;
  logic [SB_W-1:0]         p_sb_r;

  logic signed [VW-1:0]    x_r  [STEPS];
  logic signed [VW-1:0]    y_r  [STEPS];
  logic signed [ANG_W-1:0] z_r  [STEPS];
  logic                    n_r  [STEPS];
  logic                    zf_r [STEPS];
  logic [SB_W-1:0]         sb_r [STEPS];
  logic                    v_r  [STEPS];

  logic signed [VW-1:0]    xe;
  logic signed [VW-1:0]    ye;
  logic signed [ANG_W-1:0] zr;
  logic signed [16:0]      hsum;
  logic signed [16:0]      hw;

  logic                    valid_o_r;
  logic [15:0]             head_o_r;
  logic [SB_W-1:0]         sb_o_r;

  assign xe = VW'(in_xh);
  assign ye = VW'(in_yh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_neg_r  <= in_xh[53];
      p_zero_r <= (in_xh == '0) && (in_yh == '0);
      p_x_r    <= in_xh[53] ? -xe : xe;
      p_y_r    <= in_xh[53] ? -ye : ye;
      p_sb_r   <= in_sb;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stg
    logic signed [VW-1:0]    xs;
    logic signed [VW-1:0]    ys;
    logic signed [ANG_W-1:0] zs;
    logic                    ns;
    logic                    zfs;
    logic [SB_W-1:0]         sbs;
    logic                    vs;
    if (i == 0) begin : g_first
      assign xs  = p_x_r;
      assign ys  = p_y_r;
      assign zs  = '0;
      assign ns  = p_neg_r;
      assign zfs = p_zero_r;
      assign sbs = p_sb_r;
      assign vs  = p_valid_r;
    end else begin : g_next
      assign xs  = x_r[i-1];
      assign ys  = y_r[i-1];
      assign zs  = z_r[i-1];
      assign ns  = n_r[i-1];
      assign zfs = zf_r[i-1];
      assign sbs = sb_r[i-1];
      assign vs  = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[VW-1]) begin
          x_r[i] <= xs + (ys >>> i);
          y_r[i] <= ys - (xs >>> i);
          z_r[i] <= zs + atan_val(i);
        end else begin
          x_r[i] <= xs - (ys >>> i);
          y_r[i] <= ys + (xs >>> i);
          z_r[i] <= zs - atan_val(i);
        end
        n_r[i]  <= ns;
        zf_r[i] <= zfs;
        sb_r[i] <= sbs;
      end
    end
  end

  // round half up to centidegrees, add half turn when x was not negative, wrap
  always_comb begin
    zr   = (z_r[STEPS-1] + 32'sd32768) >>> 16;
    hsum = 17'(zr) + (n_r[STEPS-1] ? 17'sd0 : 17'sd18000);
    if (hsum < 17'sd0) hw = hsum + 17'sd36000;
    else if (hsum >= 17'sd36000) hw = hsum - 17'sd36000;
    else hw = hsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o_r <= 1'b0;
    end else if (en) begin
      valid_o_r <= v_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_o_r <= zf_r[STEPS-1] ? 16'd18000 : hw[15:0];
      sb_o_r   <= sb_r[STEPS-1];
    end
  end

  assign out_valid   = valid_o_r;
  assign out_heading = head_o_r;
  assign out_sb      = sb_o_r;

endmodule

`default_nettype wire
